@@ rtl/pfmax_pkg.sv @@
`default_nettype none

package pfmax_pkg;

    // Fixed field widths of the channels.
    localparam int POS_BITS  = 11;
    localparam int DATA_BITS = 32;
    localparam int SIZE_BITS = 11;

    localparam int DEPTH_DEFAULT      = 1024;
    localparam int VALUE_BITS_DEFAULT = 32;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(1024);

    // Operation codes carried on the op field.
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

endpackage

`default_nettype wire

@@ rtl/prefix_max_fenwick_tree.sv @@
`default_nettype none

// Prefix-maximum Fenwick tree. An update transaction raises every node on the
// upward lowest-set-bit walk from its position to at least the given value; a
// query transaction walks downward and returns the maximum over positions 1 to
// its position (clamped to the size in use), or 0 for an empty prefix; a clear
// transaction zeroes the whole node memory. One single-port node memory with a
// registered read is shared by all walks, so each visited node takes a read state
// and then a merge state (compare and optional write back), and a query ends in an
// output state that waits until the output register is free. A clear, and the pass
// that runs right after reset, sweep the memory one node per cycle, during which
// s_ready is low. The table_size register may be written at any time on its own
// channel and is sampled when a transaction is accepted.
module prefix_max_fenwick_tree #(
    parameter int DEPTH      = pfmax_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = pfmax_pkg::VALUE_BITS_DEFAULT
) (
    input  wire                              aclk,
    input  wire                              aresetn,

    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [pfmax_pkg::SIZE_BITS-1:0]  cfg_table_size,

    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [1:0]                       s_op,
    input  wire  [pfmax_pkg::POS_BITS-1:0]   s_position,
    input  wire  [pfmax_pkg::DATA_BITS-1:0]  s_value,

    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [pfmax_pkg::DATA_BITS-1:0]  m_prefix_max
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = $clog2(DEPTH + 1);
    // Walk index width: room for any position, any size and one step past the size.
    localparam int CW = ((IW > pfmax_pkg::POS_BITS) ? IW : pfmax_pkg::POS_BITS) + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MERGE,
        ST_OUT
    } state_t;

    state_t                          state_reg, state_next;
    logic [AW-1:0]                   clr_reg, clr_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [CW-1:0]                   sz_reg, sz_next;
    logic                            is_query_reg, is_query_next;
    logic [VALUE_BITS-1:0]           val_reg, val_next;
    logic [VALUE_BITS-1:0]           acc_reg, acc_next;
    logic [pfmax_pkg::SIZE_BITS-1:0] table_size_reg, table_size_next;
    logic                            m_valid_reg, m_valid_next;
    logic [pfmax_pkg::DATA_BITS-1:0] m_data_reg, m_data_next;

    logic [VALUE_BITS-1:0] node_mem [DEPTH];
    logic [VALUE_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [AW-1:0]         idx_addr;

    logic [CW-1:0] size_ext;
    logic [CW-1:0] size_use;
    logic [CW-1:0] pos_ext;
    logic [CW-1:0] q_pos;
    logic [CW-1:0] low_bit;
    logic [CW-1:0] idx_up;
    logic [CW-1:0] idx_dn;

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_prefix_max = m_data_reg;

    assign size_ext = CW'(table_size_reg);
    assign size_use = (size_ext == '0) ? CW'(1) :
                      ((size_ext > CW'(DEPTH)) ? CW'(DEPTH) : size_ext);
    assign pos_ext  = CW'(s_position);
    assign q_pos    = (pos_ext > size_use) ? size_use : pos_ext;

    assign idx_addr = AW'(idx_reg - CW'(1));
    assign low_bit  = idx_reg & (~idx_reg + CW'(1));
    assign idx_up   = idx_reg + low_bit;
    assign idx_dn   = idx_reg ^ low_bit;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_addr;
        mem_wdata = val_reg;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end else if (state_reg == ST_MERGE && !is_query_reg && rdata_reg < val_reg) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= node_mem[idx_addr];
    end

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        sz_next         = sz_reg;
        is_query_next   = is_query_reg;
        val_next        = val_reg;
        acc_next        = acc_reg;
        table_size_next = table_size_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (cfg_valid) begin
            table_size_next = cfg_table_size;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    sz_next  = size_use;
                    val_next = VALUE_BITS'(s_value);
                    acc_next = '0;
                    case (s_op)
                        pfmax_pkg::OP_UPDATE: begin
                            is_query_next = 1'b0;
                            idx_next      = pos_ext;
                            if (pos_ext != '0 && pos_ext <= size_use) begin
                                state_next = ST_READ;
                            end
                        end
                        pfmax_pkg::OP_QUERY: begin
                            is_query_next = 1'b1;
                            idx_next      = q_pos;
                            state_next    = (q_pos == '0) ? ST_OUT : ST_READ;
                        end
                        pfmax_pkg::OP_CLEAR: begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (is_query_reg) begin
                    if (rdata_reg > acc_reg) begin
                        acc_next = rdata_reg;
                    end
                    idx_next   = idx_dn;
                    state_next = (idx_dn == '0) ? ST_OUT : ST_READ;
                end else begin
                    idx_next   = idx_up;
                    state_next = (idx_up > sz_reg) ? ST_IDLE : ST_READ;
                end
            end
            ST_OUT: begin
                // Hold the result until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pfmax_pkg::DATA_BITS'(acc_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            table_size_reg <= pfmax_pkg::SIZE_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            table_size_reg <= table_size_next;
            m_valid_reg    <= m_valid_next;
        end
        idx_reg      <= idx_next;
        sz_reg       <= sz_next;
        is_query_reg <= is_query_next;
        val_reg      <= val_next;
        acc_reg      <= acc_next;
        m_data_reg   <= m_data_next;
    end

endmodule

`default_nettype wire

@@ rtl/pfmax_checker.sv @@
`default_nettype none

module pfmax_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire [1:0]  s_op,
    input wire        m_valid,
    input wire        m_ready,
    input wire [31:0] m_prefix_max
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prefix_max))
        else $error("result changed while stalled");

    // Results only appear while the block is busy with a query.
    a_out_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while input side was idle");

    // No result can rise on the cycle right after a transaction is taken.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result produced without any memory access");

    // A clear sweeps the memory and blocks new transactions meanwhile.
    a_clear_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == pfmax_pkg::OP_CLEAR |=> !s_ready ##1 !s_ready)
        else $error("input accepted during clear sweep");

endmodule

bind prefix_max_fenwick_tree pfmax_checker u_pfmax_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_prefix_max (m_prefix_max)
);

`default_nettype wire
